// ===== rtl/core/ssfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfc_pkg
// shared constants, status codes and control structs of the name set checker
// ----------------------------------------------------------------------------
package ssfc_pkg;

	localparam int HASH_BUCKETS_DEF = 16384;
	localparam int MAX_ENTRIES_DEF  = 16384;
	localparam int MAX_NAME_LEN_DEF = 50;

	localparam logic [31:0] BKDR_SEED = 32'd131;
	localparam int CHAR_W = 7;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_WRONG     = 3'd1;
	localparam logic [2:0] ST_REPEAT    = 3'd2;
	localparam logic [2:0] ST_INSERTED  = 3'd3;
	localparam logic [2:0] ST_DUPLICATE = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_TOO_LONG  = 3'd6;

	// status of the name being collected
	typedef struct packed {
		logic [31:0] hash_next;
		logic        overlong;
		logic        op;
	} nb_stat_t;

	// enables of the table memories
	typedef struct packed {
		logic head_rd;
		logic head_we;
		logic ent_rd;
		logic ent_we;
		logic chr_rd;
		logic chr_we;
	} store_ctl_t;

endpackage

// ===== rtl/core/ssfc_name_buf.sv =====
// ----------------------------------------------------------------------------
// ssfc_name_buf
// collects the incoming name: character buffer, length, hash and operation
// ----------------------------------------------------------------------------
module ssfc_name_buf #(
	parameter int MAX_NAME_LEN = ssfc_pkg::MAX_NAME_LEN_DEF,
	parameter int LW = $clog2(MAX_NAME_LEN + 1),
	parameter int XW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr,
	input  logic                        op_in,
	input  logic [ssfc_pkg::CHAR_W-1:0] char_in,
	input  logic                        last_in,
	output ssfc_pkg::nb_stat_t          stat,
	output logic [LW-1:0]               len,
	input  logic                        rd,
	input  logic [XW-1:0]               rd_addr,
	output logic [ssfc_pkg::CHAR_W-1:0] rd_data
);

	logic [ssfc_pkg::CHAR_W-1:0] mem [MAX_NAME_LEN];
	logic [LW-1:0] len_q;
	logic [31:0]   hash_q;
	logic          op_q;
	logic          over_q;
	logic          room;
	logic [31:0]   hash_nx;

	// bkdr step
	assign hash_nx = 32'(hash_q * ssfc_pkg::BKDR_SEED) + 32'(char_in);
	assign room    = (len_q < LW'(MAX_NAME_LEN));

	assign stat.hash_next = hash_nx;
	assign stat.overlong  = over_q;
	assign stat.op        = op_q;
	assign len            = len_q;

	// running state, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			hash_q <= '0;
			op_q   <= 1'b0;
			over_q <= 1'b0;
		end else if (wr) begin
			if (last_in) begin
				len_q  <= '0;
				hash_q <= '0;
				op_q   <= 1'b0;
				over_q <= 1'b0;
			end else begin
				hash_q <= hash_nx;
				if (len_q == '0)
					op_q <= op_in;
				if (room)
					len_q <= len_q + 1'b1;
				else
					over_q <= 1'b1;
			end
		end
	end

	// character buffer
	always_ff @(posedge clk) begin
		if (wr && room)
			mem[len_q[XW-1:0]] <= char_in;
		if (rd)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/ssfc_store.sv =====
// ----------------------------------------------------------------------------
// ssfc_store
// table memories: bucket heads, entry records and stored characters
// ----------------------------------------------------------------------------
module ssfc_store #(
	parameter int HASH_BUCKETS = ssfc_pkg::HASH_BUCKETS_DEF,
	parameter int MAX_ENTRIES  = ssfc_pkg::MAX_ENTRIES_DEF,
	parameter int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1,
	parameter int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	parameter int XW = 6,
	parameter int EDW = 8
) (
	input  logic                        clk,
	input  ssfc_pkg::store_ctl_t        ctl,
	input  logic [BW-1:0]               head_addr,
	input  logic [IW:0]                 head_wdata,
	output logic [IW:0]                 head_rdata,
	input  logic [IW-1:0]               ent_addr,
	input  logic [EDW-1:0]              ent_wdata,
	output logic [EDW-1:0]              ent_rdata,
	input  logic [IW+XW-1:0]            chr_addr,
	input  logic [ssfc_pkg::CHAR_W-1:0] chr_wdata,
	output logic [ssfc_pkg::CHAR_W-1:0] chr_rdata
);

	logic [IW:0]                 head_mem [HASH_BUCKETS];
	logic [EDW-1:0]              ent_mem  [MAX_ENTRIES];
	logic [ssfc_pkg::CHAR_W-1:0] chr_mem  [MAX_ENTRIES << XW];

	// bucket heads: valid bit and entry index
	always_ff @(posedge clk) begin
		if (ctl.head_we)
			head_mem[head_addr] <= head_wdata;
		if (ctl.head_rd)
			head_rdata <= head_mem[head_addr];
	end

	// entry records: link valid, link, length, visited
	always_ff @(posedge clk) begin
		if (ctl.ent_we)
			ent_mem[ent_addr] <= ent_wdata;
		if (ctl.ent_rd)
			ent_rdata <= ent_mem[ent_addr];
	end

	// name characters, one row per entry
	always_ff @(posedge clk) begin
		if (ctl.chr_we)
			chr_mem[chr_addr] <= chr_wdata;
		if (ctl.chr_rd)
			chr_rdata <= chr_mem[chr_addr];
	end

endmodule

// ===== rtl/core/string_set_first_seen_checker.sv =====
// ----------------------------------------------------------------------------
// string_set_first_seen_checker
// roster of names in a chained hash set with first-seen roll-call checking
// ----------------------------------------------------------------------------
// Names arrive one character per transaction on start/busy with operation
// (taken from the first character), name_char and last_char. A character is
// taken when start is high and busy is low. A character that is not the last
// gives no result. The last character starts a walk of the bucket chain:
// the head is read, then each chain entry's record is read and, if the
// length matches, its characters are compared one at a time; an insert
// then copies the name one character at a time. busy stays high meanwhile.
// Each name gives one status on status, marked by done for one cycle, as
// busy falls; an overlong name reports the cycle after its last character.
// The receiver cannot stall, so results are never held back.
// After reset the bucket heads are cleared one per cycle, with busy high,
// before the first character is taken.
// ----------------------------------------------------------------------------
module string_set_first_seen_checker #(
	parameter int HASH_BUCKETS = ssfc_pkg::HASH_BUCKETS_DEF,
	parameter int MAX_ENTRIES  = ssfc_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_NAME_LEN = ssfc_pkg::MAX_NAME_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [ssfc_pkg::CHAR_W-1:0] name_char,
	input  logic                        last_char,
	output logic                        done,
	output logic [2:0]                  status
);

	localparam int BW  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int EW  = $clog2(MAX_ENTRIES + 1);
	localparam int LW  = $clog2(MAX_NAME_LEN + 1);
	localparam int XW  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
	localparam int EDW = IW + LW + 2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_HEAD_W, S_WALK, S_ENT_W,
		S_CMP_RD, S_CMP_CK, S_FOUND, S_NOTFOUND, S_CP_RD, S_CP_WR
	} state_t;

	state_t state_q;
	logic [BW-1:0] clr_q;
	logic [BW-1:0] bucket_q;
	logic          op_q;
	logic [LW-1:0] len_q;
	logic [IW:0]   head_q;
	logic          cur_v_q;
	logic [IW-1:0] cur_q;
	logic [XW-1:0] idx_q;
	logic [EW-1:0] used_q;
	logic          done_q;
	logic [2:0]    status_q;

	ssfc_pkg::nb_stat_t   nb_stat;
	ssfc_pkg::store_ctl_t ctl;
	logic [LW-1:0]               nb_len;
	logic                        nb_rd;
	logic [ssfc_pkg::CHAR_W-1:0] nb_rdata;
	logic [BW-1:0]               head_addr;
	logic [IW:0]                 head_wdata, head_rdata;
	logic [IW-1:0]               ent_addr;
	logic [EDW-1:0]              ent_wdata, ent_rdata;
	logic [IW+XW-1:0]            chr_addr;
	logic [ssfc_pkg::CHAR_W-1:0] chr_rdata;

	logic          accept;
	logic          ent_visited, ent_link_v;
	logic [LW-1:0] ent_len;
	logic [IW-1:0] ent_link;
	logic          full;
	logic          idx_last;

	assign accept      = start && !busy;
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign ent_visited = ent_rdata[0];
	assign ent_len     = ent_rdata[LW:1];
	assign ent_link    = ent_rdata[LW+IW:LW+1];
	assign ent_link_v  = ent_rdata[LW+IW+1];
	assign full        = (used_q == EW'(MAX_ENTRIES));
	assign idx_last    = (LW'(idx_q) == len_q - 1'b1);

	ssfc_name_buf #(.MAX_NAME_LEN(MAX_NAME_LEN), .LW(LW), .XW(XW)) u_name_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.op_in   (operation),
		.char_in (name_char),
		.last_in (last_char),
		.stat    (nb_stat),
		.len     (nb_len),
		.rd      (nb_rd),
		.rd_addr (idx_q),
		.rd_data (nb_rdata)
	);

	ssfc_store #(
		.HASH_BUCKETS(HASH_BUCKETS), .MAX_ENTRIES(MAX_ENTRIES),
		.BW(BW), .IW(IW), .XW(XW), .EDW(EDW)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.head_addr  (head_addr),
		.head_wdata (head_wdata),
		.head_rdata (head_rdata),
		.ent_addr   (ent_addr),
		.ent_wdata  (ent_wdata),
		.ent_rdata  (ent_rdata),
		.chr_addr   (chr_addr),
		.chr_wdata  (nb_rdata),
		.chr_rdata  (chr_rdata)
	);

	// memory control per state
	always_comb begin
		ctl        = '0;
		nb_rd      = 1'b0;
		head_addr  = (state_q == S_CLEAR) ? clr_q : bucket_q;
		head_wdata = '0;
		ent_addr   = cur_q;
		ent_wdata  = {ent_rdata[EDW-1:1], 1'b1};
		chr_addr   = {cur_q, idx_q};
		unique case (state_q)
			S_CLEAR: ctl.head_we = 1'b1;
			S_HEAD: ctl.head_rd = 1'b1;
			S_WALK: ctl.ent_rd = cur_v_q;
			S_CMP_RD: begin
				ctl.chr_rd = 1'b1;
				nb_rd      = 1'b1;
			end
			S_FOUND: ctl.ent_we = op_q && !ent_visited;
			S_NOTFOUND: begin
				ctl.ent_we = !op_q && !full;
				ctl.head_we = !op_q && !full;
				ent_addr   = used_q[IW-1:0];
				ent_wdata  = {head_q, len_q, 1'b0};
				head_wdata = {1'b1, used_q[IW-1:0]};
			end
			S_CP_RD: nb_rd = 1'b1;
			S_CP_WR: begin
				ctl.chr_we = 1'b1;
				chr_addr   = {used_q[IW-1:0], idx_q};
			end
			default: ;
		endcase
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			used_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ssfc_pkg::ST_OK;
			bucket_q <= '0;
			op_q     <= 1'b0;
			len_q    <= '0;
			head_q   <= '0;
			cur_v_q  <= 1'b0;
			cur_q    <= '0;
			idx_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(HASH_BUCKETS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept && last_char) begin
						if (nb_stat.overlong || nb_len == LW'(MAX_NAME_LEN)) begin
							done_q   <= 1'b1;
							status_q <= ssfc_pkg::ST_TOO_LONG;
						end else begin
							bucket_q <= nb_stat.hash_next[BW-1:0] & BW'(HASH_BUCKETS - 1);
							op_q     <= (nb_len == '0) ? operation : nb_stat.op;
							len_q    <= nb_len + 1'b1;
							state_q  <= S_HEAD;
						end
					end
				end
				S_HEAD: state_q <= S_HEAD_W;
				S_HEAD_W: begin
					head_q  <= head_rdata;
					cur_v_q <= head_rdata[IW];
					cur_q   <= head_rdata[IW-1:0];
					state_q <= S_WALK;
				end
				S_WALK: state_q <= cur_v_q ? S_ENT_W : S_NOTFOUND;
				S_ENT_W: begin
					idx_q <= '0;
					if (ent_len != len_q) begin
						cur_v_q <= ent_link_v;
						cur_q   <= ent_link;
						state_q <= S_WALK;
					end else begin
						state_q <= S_CMP_RD;
					end
				end
				S_CMP_RD: state_q <= S_CMP_CK;
				S_CMP_CK: begin
					if (chr_rdata != nb_rdata) begin
						cur_v_q <= ent_link_v;
						cur_q   <= ent_link;
						state_q <= S_WALK;
					end else if (idx_last) begin
						state_q <= S_FOUND;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_CMP_RD;
					end
				end
				S_FOUND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (!op_q)
						status_q <= ssfc_pkg::ST_DUPLICATE;
					else if (!ent_visited)
						status_q <= ssfc_pkg::ST_OK;
					else
						status_q <= ssfc_pkg::ST_REPEAT;
				end
				S_NOTFOUND: begin
					idx_q <= '0;
					if (op_q) begin
						done_q   <= 1'b1;
						status_q <= ssfc_pkg::ST_WRONG;
						state_q  <= S_IDLE;
					end else if (full) begin
						done_q   <= 1'b1;
						status_q <= ssfc_pkg::ST_FULL;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_CP_RD;
					end
				end
				S_CP_RD: state_q <= S_CP_WR;
				S_CP_WR: begin
					if (idx_last) begin
						used_q   <= used_q + 1'b1;
						done_q   <= 1'b1;
						status_q <= ssfc_pkg::ST_INSERTED;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_CP_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/ssfc_checker.sv =====
// ----------------------------------------------------------------------------
// ssfc_checker
// port-level assertions of the name set checker, bound to the top level
// ----------------------------------------------------------------------------
module ssfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       last_char,
	input logic       done,
	input logic [2:0] status
);

	// status codes stop at too long
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 3'd7))
		else $error("status code out of range");

	// every name has at least one character, so results never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// a result is only posted while the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// a character that does not end a name never starts a walk
	a_mid_char: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_char) |=> (!busy && !done))
		else $error("busy or result after a middle character");

endmodule

bind string_set_first_seen_checker ssfc_checker u_ssfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last_char (last_char),
	.done      (done),
	.status    (status)
);

// ===== tb/string_set_first_seen_checker_test.sv =====
// ----------------------------------------------------------------------------
// string_set_first_seen_checker_test
// self-checking bench: names are sent one character per transaction with
// random spacing, a behavioral roster predicts every status and a scoreboard
// compares each done strobe with the oldest prediction
// ----------------------------------------------------------------------------
module string_set_first_seen_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBUCKETS = ssfc_pkg::HASH_BUCKETS_DEF;
	localparam int NENTRIES = ssfc_pkg::MAX_ENTRIES_DEF;
	localparam int NAMELEN  = ssfc_pkg::MAX_NAME_LEN_DEF;

	// scoreboard of predicted statuses
	class status_scoreboard;
		logic [2:0] pending_status[$];
		int         errors;

		function void note_status(logic [2:0] st);
			pending_status.push_back(st);
		endfunction

		function void check_status(logic [2:0] got);
			logic [2:0] want;
			if (pending_status.size() == 0) begin
				$error("status: no transaction expected, actual %0d", got);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (want !== got) begin
					$error("status: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          operation;
	logic [ssfc_pkg::CHAR_W-1:0]   name_char;
	logic                          last_char;
	logic                          done;
	logic [2:0]                    status;

	status_scoreboard sb;

	// roster state of the predictor
	logic [ssfc_pkg::CHAR_W-1:0] cur_name[NAMELEN];
	int                          cur_len;
	logic [31:0]                 cur_hash;
	logic                        cur_op;
	logic                        cur_over;
	int                          heads[int];
	int                          links[int];
	logic [ssfc_pkg::CHAR_W-1:0] ent_chars[int][];
	int                          ent_len[int];
	logic                        ent_seen[int];
	int                          used;

	int send_gap_pct;
	int pool_len[$];
	logic [ssfc_pkg::CHAR_W-1:0] pool_chars[$][];

	string_set_first_seen_checker DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .name_char(name_char), .last_char(last_char),
		.done(done), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("string_set_first_seen_checker verification failed");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_status(status);
	end

	function automatic int roster_find(int bucket);
		int e;
		int steps;
		bit hit;
		steps = 0;
		if (!heads.exists(bucket))
			return -1;
		e = heads[bucket];
		while (steps < NENTRIES) begin
			hit = (ent_len[e] == cur_len);
			for (int i = 0; i < cur_len && hit; i++)
				if (ent_chars[e][i] != cur_name[i])
					hit = 0;
			if (hit)
				return e;
			if (!links.exists(e))
				return -1;
			e = links[e];
			steps++;
		end
		return -1;
	endfunction

	// predictor: one character in, a status out on the last one
	function automatic void predict_char(logic op, logic [ssfc_pkg::CHAR_W-1:0] ch,
			logic last);
		int bucket;
		int e;
		logic [2:0] st;
		if (cur_len == 0 && !cur_over)
			cur_op = op;
		cur_hash = cur_hash * ssfc_pkg::BKDR_SEED + 32'(ch);
		if (cur_len < NAMELEN) begin
			cur_name[cur_len] = ch;
			cur_len++;
		end else
			cur_over = 1'b1;
		if (!last)
			return;
		bucket = int'(cur_hash % NBUCKETS);
		if (cur_over)
			st = ssfc_pkg::ST_TOO_LONG;
		else if (cur_op == 1'b0) begin
			e = roster_find(bucket);
			if (e >= 0)
				st = ssfc_pkg::ST_DUPLICATE;
			else if (used >= NENTRIES)
				st = ssfc_pkg::ST_FULL;
			else begin
				ent_chars[used] = new[cur_len];
				for (int i = 0; i < cur_len; i++)
					ent_chars[used][i] = cur_name[i];
				ent_len[used] = cur_len;
				ent_seen[used] = 1'b0;
				if (heads.exists(bucket))
					links[used] = heads[bucket];
				heads[bucket] = used;
				used++;
				st = ssfc_pkg::ST_INSERTED;
			end
		end else begin
			e = roster_find(bucket);
			if (e < 0)
				st = ssfc_pkg::ST_WRONG;
			else if (!ent_seen[e]) begin
				ent_seen[e] = 1'b1;
				st = ssfc_pkg::ST_OK;
			end else
				st = ssfc_pkg::ST_REPEAT;
		end
		sb.note_status(st);
		cur_len = 0;
		cur_hash = '0;
		cur_op = 1'b0;
		cur_over = 1'b0;
	endfunction

	// one character transaction
	task automatic send_char(logic op, logic [ssfc_pkg::CHAR_W-1:0] ch, logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			operation <= 1'($urandom);
			name_char <= 7'($urandom);
			last_char <= 1'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		name_char <= ch;
		last_char <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_char(op, ch, last);
		@(negedge clk);
	endtask

	// whole name; later characters carry random operation bits
	task automatic send_name(logic op, logic [ssfc_pkg::CHAR_W-1:0] chars[], int n);
		for (int i = 0; i < n; i++)
			send_char(i == 0 ? op : 1'($urandom), chars[i], i == n - 1);
	endtask

	task automatic send_letters(logic op, int n, bit wide, bit remember);
		logic [ssfc_pkg::CHAR_W-1:0] c[];
		c = new[n];
		for (int i = 0; i < n; i++)
			c[i] = wide ? 7'($urandom) : 7'($urandom_range(122, 97));
		if (remember) begin
			pool_chars.push_back(c);
			pool_len.push_back(n);
		end
		send_name(op, c, n);
	endtask

	task automatic send_known(logic op);
		int k;
		if (pool_len.size() == 0)
			send_letters(op, 3, 0, 1);
		else begin
			k = $urandom_range(pool_len.size() - 1);
			send_name(op, pool_chars[k], pool_len[k]);
		end
	endtask

	task automatic wait_quiet();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (sb.pending_status.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (300) @(negedge clk);
	endtask

	initial begin
		logic [ssfc_pkg::CHAR_W-1:0] c[];
		int pick;
		sb = new();
		start = 1'b0;
		operation = 1'b0;
		name_char = '0;
		last_char = 1'b0;
		arst_n = 1'b0;
		cur_len = 0;
		cur_hash = '0;
		cur_op = 1'b0;
		cur_over = 1'b0;
		used = 0;
		send_gap_pct = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, duplicates, repeats, overlong and odd codes
		c = new[1];
		c[0] = 7'd97;
		send_name(1'b1, c, 1);
		send_name(1'b0, c, 1);
		send_name(1'b0, c, 1);
		send_name(1'b1, c, 1);
		send_name(1'b1, c, 1);
		c[0] = 7'd122;
		send_name(1'b0, c, 1);
		c = new[NAMELEN];
		foreach (c[i]) c[i] = 7'd122;
		send_name(1'b0, c, NAMELEN);
		send_name(1'b1, c, NAMELEN);
		c = new[NAMELEN + 1];
		foreach (c[i]) c[i] = 7'd97;
		send_name(1'b0, c, NAMELEN + 1);
		send_name(1'b1, c, NAMELEN + 1);
		c = new[2];
		c[0] = 7'd0;
		c[1] = 7'd127;
		send_name(1'b0, c, 2);
		send_name(1'b1, c, 2);
		c[0] = 7'd127;
		c[1] = 7'd0;
		send_name(1'b1, c, 2);
		wait_quiet();

		// random phases with different sender spacing
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 0) ? 0 : (ph == 1) ? 83 : (ph == 2) ? 12 : 0;
			repeat (75) begin
				pick = $urandom_range(99);
				if (pick < 35)
					send_letters(1'b0, $urandom_range(4, 1), 0, 1);
				else if (pick < 75)
					send_known(1'b1);
				else if (pick < 85)
					send_known(1'b0);
				else if (pick < 92)
					send_letters(1'b1, $urandom_range(3, 1), 0, 0);
				else if (pick < 97)
					send_letters(1'($urandom), $urandom_range(4, 1), 1, 1);
				else
					send_letters(1'($urandom), $urandom_range(NAMELEN + 3, 40), 0, 0);
			end
			wait_quiet();
		end

		if (sb.errors == 0 && sb.pending_status.size() == 0)
			$display("string_set_first_seen_checker verification clean");
		else
			$display("string_set_first_seen_checker verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/ssfc_pkg.sv
rtl/core/ssfc_name_buf.sv
rtl/core/ssfc_store.sv
rtl/core/string_set_first_seen_checker.sv
rtl/core/ssfc_checker.sv
tb/string_set_first_seen_checker_test.sv
